/* src/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg: shared definitions of the soft knee clipper
// Register codes, reset values, fixed widths and the rational tanh constants.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

    localparam int SAMPLE_FRAC_BITS_DEF = 28;

    // Configuration register codes
    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_KNEE      = 2'd1,
        CFG_ASYM      = 2'd2
    } t_cfg_reg;

    localparam logic [15:0] THRESHOLD_RST = 16'd62259;
    localparam logic [15:0] KNEE_RST      = 16'd3277;
    localparam logic [15:0] ASYM_RST      = 16'd0;

    // Threshold and knee at sample scale, wide enough for every fraction width
    localparam int TK_W = 31;

    // Quotient lengths of the three dividers
    localparam int T_QB  = 30;
    localparam int U_QB  = 25;
    localparam int TH_QB = 30;

    localparam int T_NW  = 32;
    localparam int U_NW  = 34;
    localparam int TH_NW = 41;

    // Fraction bits of the tanh polynomial
    localparam int PF = 22;

    localparam logic [30:0] ONE30 = 31'h4000_0000;

    localparam logic [32:0] C_NIN  = 33'(64'd1260  << PF);
    localparam logic [29:0] C_DIN  = 30'(64'd210   << PF);
    localparam logic [37:0] C_NMID = 38'(64'd10395 << PF);
    localparam logic [35:0] C_DMID = 36'(64'd4725  << PF);
    localparam logic [40:0] C_DEN  = 41'(64'd10395 << PF);

endpackage

`default_nettype wire

/* src/soft_knee_tanh_clipper.sv */
// ----------------------------------------------------------------------------
// soft_knee_tanh_clipper: soft clipper with a rational tanh knee
// Passes small samples unchanged and bends larger ones towards the threshold
// through a smoothstep blend with a Pade tanh, with optional extra
// attenuation of the negative half beyond the pass region; a zero knee hard clips.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample_in; tlast: block_last_in
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: sample_out; tlast: block_last_out
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One item enters per cycle while the pipeline is not halted.
//  The depth is set by the tanh path: a 25 stage divider for the argument,
//  six stages of polynomial products, a 30 stage divider for the ratio and
//  six stages of blending and saturation.
//  The whole pipeline advances together; it halts only while a result waits
//  in the output register and the sink is not ready.
//  Reset clears the valid bits and loads the default register values; the
//  configuration port is always ready.
//
`default_nettype none

module soft_knee_tanh_clipper #(
    parameter int SAMPLE_FRAC_BITS = skt_pkg::SAMPLE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sample_out
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    import skt_pkg::*;

    localparam int SH = SAMPLE_FRAC_BITS - 16;

    // Stage numbers: each field is written at the stage named and carried on.
    localparam int ST_IN    = 0;
    localparam int ST_FRONT = 1;
    localparam int ST_T     = ST_FRONT + T_QB;      // t leaves its divider
    localparam int ST_T2    = ST_T + 1;
    localparam int ST_W     = ST_T2 + 1;
    localparam int ST_G     = ST_W + 1;
    localparam int ST_U     = ST_FRONT + U_QB;      // u leaves its divider
    localparam int ST_U2    = ST_U + 1;
    localparam int ST_NIN   = ST_U2 + 1;
    localparam int ST_P1    = ST_NIN + 1;
    localparam int ST_MID   = ST_P1 + 1;
    localparam int ST_P2    = ST_MID + 1;
    localparam int ST_ND    = ST_P2 + 1;
    localparam int ST_GE    = ST_ND + 1;
    localparam int ST_TH    = ST_ND + TH_QB;        // ratio leaves its divider
    localparam int ST_TERM  = ST_TH + 1;
    localparam int ST_CMA   = ST_TERM + 1;
    localparam int ST_PROD  = ST_CMA + 1;
    localparam int ST_MIX   = ST_PROD + 1;
    localparam int ST_GAIN  = ST_MIX + 1;
    localparam int ST_OUT   = ST_GAIN + 1;
    localparam int NSTG     = ST_OUT + 1;

    typedef struct packed {
        logic [31:0]     x;
        logic            last;
        logic [31:0]     a;
        logic            hard;
        logic            pass;
        logic            xpos;
        logic            wsat;
        logic            thsat;
        logic            diffneg;
        logic [31:0]     sres;
        logic [31:0]     d;
        logic [31:0]     adiff;
        logic [29:0]     t;
        logic [29:0]     t2;
        logic [30:0]     w;
        logic [30:0]     g;
        logic [24:0]     u;
        logic [26:0]     u2;
        logic [32:0]     nin;
        logic [29:0]     din;
        logic [43:0]     pn_lo;
        logic [42:0]     pn_hi;
        logic [56:0]     pd;
        logic [37:0]     nmid;
        logic [35:0]     dmid;
        logic [43:0]     pm_lo;
        logic [43:0]     pm_hi;
        logic [44:0]     pe_lo;
        logic [44:0]     pe_hi;
        logic [40:0]     num;
        logic [40:0]     den;
        logic            thge;
        logic [30:0]     term;
        logic [33:0]     cma;
        logic [32:0]     prod;
        logic [33:0]     mixed;
        logic [31:0]     gmag;
        logic            mneg;
        logic [31:0]     res;
    } t_stage;

    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic signed [33:0] sv;
        sv = $signed(v);
        if (sv > 34'sh0_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (sv < -34'sh0_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The user must change them only while the block
    // is idle; the block does not enforce this. Every stage reads them directly.
    // ------------------------------------------------------------------
    logic [15:0]     r_thr;
    logic [15:0]     r_knee;
    logic [15:0]     r_asym;
    logic [TK_W-1:0] ts;
    logic [TK_W-1:0] ks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THRESHOLD_RST;
            r_knee <= KNEE_RST;
            r_asym <= ASYM_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_THRESHOLD: r_thr  <= i_cfg_data;
                CFG_KNEE:      r_knee <= i_cfg_data;
                CFG_ASYM:      r_asym <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign ts = TK_W'(r_thr) << SH;
    assign ks = TK_W'(r_knee) << SH;

    // ------------------------------------------------------------------
    // Pipeline registers. All stages move on the same enable.
    // ------------------------------------------------------------------
    t_stage            r_stg [NSTG];
    t_stage            n_stg [NSTG];
    logic [NSTG-1:0]   r_vld;
    logic              en;

    logic [T_QB-1:0]   t_quo;
    logic [U_QB-1:0]   u_quo;
    logic [TH_QB-1:0]  th_quo;
    logic [T_NW-1:0]   t_num;
    logic [U_NW-1:0]   u_num;
    logic [TH_NW-1:0]  th_num;

    assign en            = !r_vld[ST_OUT] || m_axis_tready;
    assign s_axis_tready = en;

    // Divider feeds: items that never use a quotient send a zero dividend so
    // the dividend stays below the divisor.
    assign t_num  = (r_stg[ST_FRONT].pass || r_stg[ST_FRONT].wsat || r_stg[ST_FRONT].hard)
                    ? '0 : r_stg[ST_FRONT].d;
    assign u_num  = (r_stg[ST_FRONT].pass || r_stg[ST_FRONT].thsat || r_stg[ST_FRONT].hard)
                    ? '0 : {2'b00, r_stg[ST_FRONT].adiff};
    assign th_num = (r_stg[ST_ND].num >= r_stg[ST_ND].den) ? '0 : r_stg[ST_ND].num;

    skt_frac_div #(.NW(T_NW), .QB(T_QB)) u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (t_num),
        .i_den ({ks, 1'b0}),
        .o_quo (t_quo)
    );

    // The argument quotient has three integer bits: divide by eight times
    // the knee and take 25 fraction bits.
    skt_frac_div #(.NW(U_NW), .QB(U_QB)) u_div_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (u_num),
        .i_den ({ks, 3'b000}),
        .o_quo (u_quo)
    );

    skt_frac_div #(.NW(TH_NW), .QB(TH_QB)) u_div_th (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (th_num),
        .i_den (r_stg[ST_ND].den),
        .o_quo (th_quo)
    );

    always_comb begin
        logic signed [33:0] xs;
        logic [31:0]        a;
        logic signed [33:0] as;
        logic signed [33:0] cs;
        logic signed [33:0] d34;
        logic signed [33:0] diff34;
        logic signed [33:0] tss;
        logic [30:0]        th_eff;
        logic [33:0]        clip34;
        logic [32:0]        cmag;
        logic [31:0]        mmag;
        logic [33:0]        gsig;

        xs = $signed({{2{r_stg[ST_IN].x[31]}}, r_stg[ST_IN].x});
        a  = r_stg[ST_IN].x[31] ? (~r_stg[ST_IN].x + 32'd1) : r_stg[ST_IN].x;
        as = $signed({2'b00, a});
        tss = $signed({3'b000, ts});
        cs = tss - $signed({3'b000, ks});
        d34 = as - cs;
        diff34 = as - tss;
        th_eff = '0;
        clip34 = '0;
        cmag = '0;
        mmag = '0;
        gsig = '0;

        n_stg[ST_IN]      = r_stg[ST_IN];
        n_stg[ST_IN].x    = s_axis_tdata;
        n_stg[ST_IN].last = s_axis_tlast;
        for (int k = 1; k < NSTG; k++) begin
            n_stg[k] = r_stg[k-1];
        end

        // Front: magnitude, region decisions and the hard clip result
        n_stg[ST_FRONT].a       = a;
        n_stg[ST_FRONT].hard    = (r_knee == 16'd0);
        n_stg[ST_FRONT].pass    = (as <= cs);
        n_stg[ST_FRONT].xpos    = (xs > 34'sd0);
        n_stg[ST_FRONT].d       = d34[31:0];
        n_stg[ST_FRONT].wsat    = (d34 >= $signed({2'b00, ks, 1'b0}));
        n_stg[ST_FRONT].diffneg = diff34[33];
        n_stg[ST_FRONT].adiff   = diff34[33] ? 32'(-diff34) : diff34[31:0];
        n_stg[ST_FRONT].thsat   = ({3'b000, n_stg[ST_FRONT].adiff, 1'b0} >=
                                   36'(36'(ks) * 36'd9));
        if (r_knee != 16'd0) begin
            n_stg[ST_FRONT].sres = r_stg[ST_IN].x;
        end else if (xs > tss) begin
            n_stg[ST_FRONT].sres = 32'(ts);
        end else if (xs < -tss) begin
            n_stg[ST_FRONT].sres = 32'(-tss);
        end else begin
            n_stg[ST_FRONT].sres = r_stg[ST_IN].x;
        end

        // Smoothstep weight and negative gain
        n_stg[ST_T2].t  = t_quo;
        n_stg[ST_T2].t2 = 30'((60'(t_quo) * 60'(t_quo)) >> 30);
        n_stg[ST_W].w   = r_stg[ST_T2].wsat ? ONE30 :
                          31'((62'(r_stg[ST_T2].t2) *
                               62'(32'h C000_0000 - {1'b0, r_stg[ST_T2].t, 1'b0})) >> 30);
        n_stg[ST_G].g   = ONE30 - 31'((47'(r_asym) * 47'(r_stg[ST_W].w)) >> 16);

        // Pade tanh numerator and denominator, wide products split in two
        n_stg[ST_U2].u   = u_quo;
        n_stg[ST_U2].u2  = 27'((50'(u_quo) * 50'(u_quo)) >> PF);
        n_stg[ST_NIN].nin = C_NIN + 33'(33'(r_stg[ST_U2].u2) * 33'd21);
        n_stg[ST_NIN].din = C_DIN + 30'(r_stg[ST_U2].u2);
        n_stg[ST_P1].pn_lo = 44'(r_stg[ST_NIN].u2) * 44'(r_stg[ST_NIN].nin[16:0]);
        n_stg[ST_P1].pn_hi = 43'(r_stg[ST_NIN].u2) * 43'(r_stg[ST_NIN].nin[32:17]);
        n_stg[ST_P1].pd    = 57'(r_stg[ST_NIN].u2) * 57'(r_stg[ST_NIN].din);
        n_stg[ST_MID].nmid = C_NMID + 38'(({r_stg[ST_P1].pn_hi, 17'b0} +
                                           60'(r_stg[ST_P1].pn_lo)) >> PF);
        n_stg[ST_MID].dmid = C_DMID + 36'(r_stg[ST_P1].pd >> PF);
        n_stg[ST_P2].pm_lo = 44'(r_stg[ST_MID].u) * 44'(r_stg[ST_MID].nmid[18:0]);
        n_stg[ST_P2].pm_hi = 44'(r_stg[ST_MID].u) * 44'(r_stg[ST_MID].nmid[37:19]);
        n_stg[ST_P2].pe_lo = 45'(r_stg[ST_MID].u2) * 45'(r_stg[ST_MID].dmid[17:0]);
        n_stg[ST_P2].pe_hi = 45'(r_stg[ST_MID].u2) * 45'(r_stg[ST_MID].dmid[35:18]);
        n_stg[ST_ND].num = 41'(({r_stg[ST_P2].pm_hi, 19'b0} +
                                63'(r_stg[ST_P2].pm_lo)) >> PF);
        n_stg[ST_ND].den = C_DEN + 41'(({r_stg[ST_P2].pe_hi, 18'b0} +
                                        63'(r_stg[ST_P2].pe_lo)) >> PF);
        // A ratio of one or more is held at one
        n_stg[ST_GE].thge = (r_stg[ST_ND].num >= r_stg[ST_ND].den);

        // Knee curve and blend
        th_eff = (r_stg[ST_TH].thsat || r_stg[ST_TH].thge) ? ONE30 : {1'b0, th_quo};
        n_stg[ST_TERM].term = 31'((62'(ks) * 62'(th_eff)) >> 30);
        clip34 = r_stg[ST_TERM].diffneg ? 34'($signed({3'b000, ts}) - $signed({3'b000, r_stg[ST_TERM].term}))
                                        : 34'({3'b000, ts} + {3'b000, r_stg[ST_TERM].term});
        n_stg[ST_CMA].cma = clip34 - {2'b00, r_stg[ST_TERM].a};
        cmag = r_stg[ST_CMA].cma[33] ? 33'(-r_stg[ST_CMA].cma) : r_stg[ST_CMA].cma[32:0];
        n_stg[ST_PROD].prod = 33'((64'(cmag) * 64'(r_stg[ST_CMA].w)) >> 30);
        n_stg[ST_MIX].mixed = r_stg[ST_PROD].cma[33]
                              ? ({2'b00, r_stg[ST_PROD].a} - {1'b0, r_stg[ST_PROD].prod})
                              : ({2'b00, r_stg[ST_PROD].a} + {1'b0, r_stg[ST_PROD].prod});
        mmag = r_stg[ST_MIX].mixed[33] ? 32'(-r_stg[ST_MIX].mixed) : r_stg[ST_MIX].mixed[31:0];
        n_stg[ST_GAIN].gmag = 32'((63'(mmag) * 63'(r_stg[ST_MIX].g)) >> 30);
        n_stg[ST_GAIN].mneg = r_stg[ST_MIX].mixed[33];

        // Output selection and saturation; a non-positive input takes the gain
        gsig = r_stg[ST_GAIN].mneg ? {2'b00, r_stg[ST_GAIN].gmag}
                                   : 34'(-{2'b00, r_stg[ST_GAIN].gmag});
        if (r_stg[ST_GAIN].hard || r_stg[ST_GAIN].pass) begin
            n_stg[ST_OUT].res = r_stg[ST_GAIN].sres;
        end else if (r_stg[ST_GAIN].xpos) begin
            n_stg[ST_OUT].res = sat32(r_stg[ST_GAIN].mixed);
        end else begin
            n_stg[ST_OUT].res = sat32(gsig);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_stg <= n_stg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    assign m_axis_tvalid = r_vld[ST_OUT];
    assign m_axis_tdata  = r_stg[ST_OUT].res;
    assign m_axis_tlast  = r_stg[ST_OUT].last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while the output is stalled");

    a_pass_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_OUT] && r_stg[ST_OUT].pass |-> r_stg[ST_OUT].res == r_stg[ST_OUT].x)
        else $error("sample below the knee was altered");

    a_weight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_G] |-> r_stg[ST_G].w <= ONE30)
        else $error("knee weight above one");

endmodule

`default_nettype wire

/* src/skt_frac_div.sv */
// ----------------------------------------------------------------------------
// skt_frac_div: pipelined restoring fractional divider
// Gives floor(num * 2^QB / den) for num < den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_frac_div #(
    parameter int NW = 32,
    parameter int QB = 30
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    logic [NW-1:0] r_rem [QB];
    logic [NW-1:0] n_rem [QB];
    logic [NW-1:0] r_den [QB];
    logic [NW-1:0] n_den [QB];
    logic [QB-1:0] r_quo [QB];
    logic [QB-1:0] n_quo [QB];

    always_comb begin
        logic [NW-1:0] p_rem;
        logic [NW-1:0] p_den;
        logic [QB-1:0] p_quo;
        logic [NW:0]   sh;
        for (int k = 0; k < QB; k++) begin
            if (k == 0) begin
                p_rem = i_num;
                p_den = i_den;
                p_quo = '0;
            end else begin
                p_rem = r_rem[k-1];
                p_den = r_den[k-1];
                p_quo = r_quo[k-1];
            end
            sh = {p_rem, 1'b0};
            if (sh >= {1'b0, p_den}) begin
                n_rem[k] = NW'(sh - {1'b0, p_den});
                n_quo[k] = {p_quo[QB-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[NW-1:0];
                n_quo[k] = {p_quo[QB-2:0], 1'b0};
            end
            n_den[k] = p_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= n_den;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

`default_nettype wire
